### design/drbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_pkg
// Shared types and constants of the gated bilinear depth remap core.
// ----------------------------------------------------------------------------
package drbg_pkg;

    localparam int COORD_W     = 24;
    localparam int DEPTH_W     = 16;
    localparam int SIZE_W      = 15;
    localparam int CFG_INDEX_W = 8;
    localparam int IN_W        = 2 * COORD_W + 4 * DEPTH_W;
    localparam int NUM_STAGES  = 6;
    localparam int NUM_NBR     = 4;

    // The threshold avg / 100 is taken as ((avg >> 2) * 5243) >> 17, exact for 16-bit avg.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 17;
    localparam int THR_W       = 10;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 13'd5243;

    localparam logic [SIZE_W-1:0] RAW_WIDTH_RESET  = 15'd640;
    localparam logic [SIZE_W-1:0] RAW_HEIGHT_RESET = 15'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_RAW_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RAW_HEIGHT = 8'd1;

    typedef logic [DEPTH_W-1:0] depth_t;

    typedef enum logic [1:0] {
        OUT_INTERP     = 2'd0,
        OUT_BOUNDS     = 2'd1,
        OUT_ZERO_NBR   = 2'd2,
        OUT_INCONSIST  = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctl_t;

endpackage

### design/drbg_pipe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_pipe_ctrl
// Valid bits and per-stage load enables of the six-stage pipeline. A stage
// loads when it is empty or when the stage after it loads, so bubbles close
// up under a stalled output.
// ----------------------------------------------------------------------------
module drbg_pipe_ctrl
    import drbg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output pipe_ctl_t ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    always_comb begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next = valid_reg;
        if (load[0]) begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (load[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.en    = load;
    assign in_ready  = load[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

### design/drbg_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_gate
// Classification path: bounds check, zero neighbour check, mean and
// threshold, consistency test, and the resulting outcome code.
// ----------------------------------------------------------------------------
module drbg_gate
    import drbg_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic               aclk,
    input  pipe_ctl_t          ctl,
    input  logic [COORD_W-1:0] map_x,
    input  logic [COORD_W-1:0] map_y,
    input  depth_t             nbr [NUM_NBR],
    input  logic [SIZE_W-1:0]  raw_width,
    input  logic [SIZE_W-1:0]  raw_height,
    output outcome_t           outcome
);

    localparam int XW    = COORD_W - FRAC_BITS;
    localparam int SUM_W = DEPTH_W + 2;
    localparam int PTH_W = DEPTH_W + RECIP_W;

    logic [COORD_W-1:0] mx_reg;
    logic [COORD_W-1:0] my_reg;
    depth_t             d1_reg [NUM_NBR];

    logic [XW-1:0]      xh;
    logic [XW-1:0]      yh;
    logic               oob;
    logic               zero_nbr;
    logic [SUM_W-1:0]   sum4;

    logic               oob_reg;
    logic               zero_reg;
    depth_t             avg_reg;
    depth_t             d2_reg [NUM_NBR];

    logic [PTH_W-1:0]   thr_prod_reg;
    depth_t             diff_reg [NUM_NBR];
    outcome_t           code3_reg;

    logic [THR_W-1:0]   thr;
    logic               consistent;
    outcome_t           code4_next;
    outcome_t           code4_reg;
    outcome_t           code5_reg;
    outcome_t           code6_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            mx_reg <= map_x;
            my_reg <= map_y;
            d1_reg <= nbr;
        end
    end

    always_comb begin
        xh = XW'(mx_reg[COORD_W-2:FRAC_BITS]) + XW'(|mx_reg[FRAC_BITS-1:0]);
        yh = XW'(my_reg[COORD_W-2:FRAC_BITS]) + XW'(|my_reg[FRAC_BITS-1:0]);
        oob = mx_reg[COORD_W-1] || my_reg[COORD_W-1] ||
              (COORD_W'(xh) >= COORD_W'(raw_width)) ||
              (COORD_W'(yh) >= COORD_W'(raw_height));
        zero_nbr = 1'b0;
        sum4     = '0;
        for (int i = 0; i < NUM_NBR; i++) begin
            zero_nbr = zero_nbr || (d1_reg[i] == '0);
            sum4     = sum4 + SUM_W'(d1_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[1]) begin
            oob_reg  <= oob;
            zero_reg <= zero_nbr;
            avg_reg  <= sum4[SUM_W-1:2];
            d2_reg   <= d1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[2]) begin
            thr_prod_reg <= PTH_W'(avg_reg[DEPTH_W-1:2]) * PTH_W'(RECIP_MUL);
            for (int i = 0; i < NUM_NBR; i++) begin
                diff_reg[i] <= (d2_reg[i] >= avg_reg) ? (d2_reg[i] - avg_reg)
                                                      : (avg_reg - d2_reg[i]);
            end
            if (oob_reg) begin
                code3_reg <= OUT_BOUNDS;
            end else if (zero_reg) begin
                code3_reg <= OUT_ZERO_NBR;
            end else begin
                code3_reg <= OUT_INTERP;
            end
        end
    end

    always_comb begin
        thr        = thr_prod_reg[RECIP_SHIFT +: THR_W];
        consistent = 1'b1;
        for (int i = 0; i < NUM_NBR; i++) begin
            consistent = consistent && (diff_reg[i] < DEPTH_W'(thr));
        end
        if (code3_reg != OUT_INTERP) begin
            code4_next = code3_reg;
        end else if (consistent) begin
            code4_next = OUT_INTERP;
        end else begin
            code4_next = OUT_INCONSIST;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[3]) begin
            code4_reg <= code4_next;
        end
        if (ctl.en[4]) begin
            code5_reg <= code4_reg;
        end
        if (ctl.en[5]) begin
            code6_reg <= code5_reg;
        end
    end

    assign outcome = code6_reg;

endmodule

### design/drbg_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_blend
// Bilinear blend of the four neighbours with fixed-point weights, split
// into horizontal products, horizontal sums, vertical products and the
// final sum and truncation.
// ----------------------------------------------------------------------------
module drbg_blend
    import drbg_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  pipe_ctl_t            ctl,
    input  logic [FRAC_BITS-1:0] frac_x,
    input  logic [FRAC_BITS-1:0] frac_y,
    input  depth_t               nbr [NUM_NBR],
    output depth_t               depth
);

    localparam int WW  = FRAC_BITS + 1;
    localparam int PW  = DEPTH_W + WW;
    localparam int HW  = PW + 1;
    localparam int QW  = HW + WW;
    localparam int SW  = QW + 1;
    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

    logic [FRAC_BITS-1:0] fx_reg;
    logic [FRAC_BITS-1:0] fy1_reg;
    depth_t               d_reg [NUM_NBR];

    logic [WW-1:0]        ia;
    logic [PW-1:0]        p_reg [NUM_NBR];
    logic [FRAC_BITS-1:0] fy2_reg;

    logic [HW-1:0]        top_reg;
    logic [HW-1:0]        bot_reg;
    logic [WW-1:0]        ic_reg;
    logic [WW-1:0]        c_reg;

    logic [QW-1:0]        qt_reg;
    logic [QW-1:0]        qb_reg;

    logic [SW-1:0]        total;
    depth_t               depth5_reg;
    depth_t               depth6_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            fx_reg  <= frac_x;
            fy1_reg <= frac_y;
            d_reg   <= nbr;
        end
    end

    assign ia = ONE - WW'(fx_reg);

    always_ff @(posedge aclk) begin
        if (ctl.en[1]) begin
            p_reg[0] <= PW'(d_reg[0]) * PW'(ia);
            p_reg[1] <= PW'(d_reg[1]) * PW'(fx_reg);
            p_reg[2] <= PW'(d_reg[2]) * PW'(ia);
            p_reg[3] <= PW'(d_reg[3]) * PW'(fx_reg);
            fy2_reg  <= fy1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[2]) begin
            top_reg <= HW'(p_reg[0]) + HW'(p_reg[1]);
            bot_reg <= HW'(p_reg[2]) + HW'(p_reg[3]);
            ic_reg  <= ONE - WW'(fy2_reg);
            c_reg   <= WW'(fy2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[3]) begin
            qt_reg <= QW'(top_reg) * QW'(ic_reg);
            qb_reg <= QW'(bot_reg) * QW'(c_reg);
        end
    end

    assign total = SW'(qt_reg) + SW'(qb_reg);

    always_ff @(posedge aclk) begin
        if (ctl.en[4]) begin
            depth5_reg <= total[2*FRAC_BITS +: DEPTH_W];
        end
        if (ctl.en[5]) begin
            depth6_reg <= depth5_reg;
        end
    end

    assign depth = depth6_reg;

endmodule

### design/depth_remap_bilinear_gated_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_remap_bilinear_gated_core
// Gated bilinear remap of one rectified depth pixel per transfer.
//
// The s_ channel carries one source coordinate and its four raw neighbour
// depths per transfer. The m_ channel returns one result per input transfer,
// in order: the interpolated depth in m_tdata and the outcome code in
// m_tuser (interpolated, out of bounds, zero neighbour, inconsistent
// neighbours). Rejected pixels carry depth zero.
// The cfg_ channel writes the raw image width (index 0) and height
// (index 1); other indexes are ignored. cfg_ready is always high. Writes must
// be made only while no transfer is in flight; the core does not enforce this.
// m_tvalid rises after an input transfer once the item has passed the six
// register stages of the blend path (two multiplier stages among them).
// Throughput is one transfer per cycle while m_tready is held high.
// When the receiver holds m_tready low, the result is held and empty stages
// keep filling; s_tready falls only once all six stages hold items.
// Reset clears all valid bits and sets the raw size to 640 by 480.
// ----------------------------------------------------------------------------
module depth_remap_bilinear_gated_core
    import drbg_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // map_x, map_y, depth_top_left, depth_top_right, depth_bottom_left,
    // depth_bottom_right
    input  logic [IN_W-1:0]        s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // depth_out
    output logic [DEPTH_W-1:0]     m_tdata,
    // outcome
    output logic [1:0]             m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]      cfg_data
);

    logic [SIZE_W-1:0]  raw_width_reg;
    logic [SIZE_W-1:0]  raw_height_reg;
    pipe_ctl_t          ctl;
    logic [COORD_W-1:0] map_x;
    logic [COORD_W-1:0] map_y;
    depth_t             nbr [NUM_NBR];
    outcome_t           outcome;
    depth_t             depth;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_width_reg  <= RAW_WIDTH_RESET;
            raw_height_reg <= RAW_HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RAW_WIDTH: begin
                    raw_width_reg <= cfg_data;
                end
                REG_RAW_HEIGHT: begin
                    raw_height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign map_x = s_tdata[0 +: COORD_W];
    assign map_y = s_tdata[COORD_W +: COORD_W];

    always_comb begin
        for (int i = 0; i < NUM_NBR; i++) begin
            nbr[i] = s_tdata[2*COORD_W + i*DEPTH_W +: DEPTH_W];
        end
    end

    drbg_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    drbg_gate #(
        .FRAC_BITS (FRAC_BITS)
    ) u_gate (
        .aclk       (aclk),
        .ctl        (ctl),
        .map_x      (map_x),
        .map_y      (map_y),
        .nbr        (nbr),
        .raw_width  (raw_width_reg),
        .raw_height (raw_height_reg),
        .outcome    (outcome)
    );

    drbg_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .aclk   (aclk),
        .ctl    (ctl),
        .frac_x (map_x[FRAC_BITS-1:0]),
        .frac_y (map_y[FRAC_BITS-1:0]),
        .nbr    (nbr),
        .depth  (depth)
    );

    assign m_tdata = (outcome == OUT_INTERP) ? depth : '0;
    assign m_tuser = outcome;

endmodule

### design/drbg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_checker
// Port-level checks of the gated bilinear depth remap core.
// ----------------------------------------------------------------------------
module drbg_checker
    import drbg_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [DEPTH_W-1:0] m_tdata,
    input logic [1:0]         m_tuser
);

    // A stalled result transfer keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // Rejected pixels carry depth zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != OUT_INTERP) |-> m_tdata == '0)
    else $error("rejected pixel with nonzero depth");

    // An accepted blend of nonzero neighbours is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == OUT_INTERP) |-> m_tdata != '0)
    else $error("interpolated pixel is zero");

    // With no result waiting, the pipeline always has room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind depth_remap_bilinear_gated_core drbg_checker u_drbg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the gated bilinear depth remap core.
//
// A driver feeds pixel transfers from a queue, and a monitor checks every
// result against an in-order prediction. The directed items cover the
// coordinate and depth extremes, the order of the rejection checks, small
// means and the consistency threshold. Random items then follow at several
// raw image sizes, from zero up to the largest. Idle cycles on both sides
// vary from phase to phase.
// ----------------------------------------------------------------------------
module tb;
    import drbg_pkg::*;

    localparam int FRAC_BITS   = 8;
    localparam int LATENCY     = NUM_STAGES;
    localparam int STALL_LIMIT = 1000;
    localparam logic [63:0] UNIT = 64'd1 << FRAC_BITS;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP   = 8'd255;

    typedef struct packed {
        depth_t             bottom_right;
        depth_t             bottom_left;
        depth_t             top_right;
        depth_t             top_left;
        logic [COORD_W-1:0] map_y;
        logic [COORD_W-1:0] map_x;
    } pixel_in_t;

    typedef struct {
        depth_t   depth;
        outcome_t outcome;
    } pixel_out_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [DEPTH_W-1:0]     m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]      cfg_data  = '0;

    pixel_in_t  pending_pixels[$];
    pixel_out_t expected_pixels[$];

    logic              s_fire = 1'b0;
    logic              cfg_fire = 1'b0;
    logic [SIZE_W-1:0] bound_width = RAW_WIDTH_RESET;
    logic [SIZE_W-1:0] bound_height = RAW_HEIGHT_RESET;
    int                send_idle_pct = 10;
    int                recv_stall_pct = 59;
    int                mismatches = 0;
    int                pixels_checked = 0;
    int                size_settings = 1;
    int                quiet_cycles = 0;
    int                outcome_count[4] = '{0, 0, 0, 0};

    depth_remap_bilinear_gated_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic near_mean(depth_t d, depth_t avg, depth_t thr);
        return ((d >= avg) ? d - avg : avg - d) < thr;
    endfunction

    function automatic pixel_out_t remap_pixel(pixel_in_t p, logic [SIZE_W-1:0] w,
                                               logic [SIZE_W-1:0] h);
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [COORD_W:0]     xh;
        logic [COORD_W:0]     yh;
        logic [17:0]          dsum;
        depth_t               avg;
        depth_t               thr;
        logic [63:0]          top;
        logic [63:0]          bot;
        logic [63:0]          acc;
        pixel_out_t           r;
        r.depth = '0;
        fx = p.map_x[FRAC_BITS-1:0];
        fy = p.map_y[FRAC_BITS-1:0];
        xh = (COORD_W+1)'(p.map_x >> FRAC_BITS) + (COORD_W+1)'(fx != '0);
        yh = (COORD_W+1)'(p.map_y >> FRAC_BITS) + (COORD_W+1)'(fy != '0);
        dsum = 18'(p.top_left) + 18'(p.top_right) + 18'(p.bottom_left) +
               18'(p.bottom_right);
        avg = dsum[17:2];
        thr = depth_t'(avg / 100);
        if (p.map_x[COORD_W-1] || p.map_y[COORD_W-1]) begin
            r.outcome = OUT_BOUNDS;
        end else if (xh >= (COORD_W+1)'(w) || yh >= (COORD_W+1)'(h)) begin
            r.outcome = OUT_BOUNDS;
        end else if (p.top_left == '0 || p.top_right == '0 || p.bottom_left == '0 ||
                     p.bottom_right == '0) begin
            r.outcome = OUT_ZERO_NBR;
        end else if (near_mean(p.top_left, avg, thr) && near_mean(p.top_right, avg, thr) &&
                     near_mean(p.bottom_left, avg, thr) &&
                     near_mean(p.bottom_right, avg, thr)) begin
            top = 64'(p.top_left) * (UNIT - 64'(fx)) + 64'(p.top_right) * 64'(fx);
            bot = 64'(p.bottom_left) * (UNIT - 64'(fx)) + 64'(p.bottom_right) * 64'(fx);
            acc = top * (UNIT - 64'(fy)) + bot * 64'(fy);
            r.depth = acc[2*FRAC_BITS +: DEPTH_W];
            r.outcome = OUT_INTERP;
        end else begin
            r.outcome = OUT_INCONSIST;
        end
        return r;
    endfunction

    // Driver: a new pixel is presented once the previous transfer is done.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (pending_pixels.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                s_tdata <= pending_pixels.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Monitor: tracks transfers, register writes and checks results in order.
    always @(posedge aclk) begin : check_results
        pixel_out_t want;
        if (!aresetn) begin
            s_fire <= 1'b0;
            cfg_fire <= 1'b0;
            bound_width <= RAW_WIDTH_RESET;
            bound_height <= RAW_HEIGHT_RESET;
        end else begin
            s_fire <= s_tvalid && s_tready;
            cfg_fire <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_RAW_WIDTH) begin
                    bound_width <= cfg_data;
                end else if (cfg_index == REG_RAW_HEIGHT) begin
                    bound_height <= cfg_data;
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result, depth %0d outcome %0d",
                             $time, m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    outcome_count[want.outcome]++;
                    if (m_tdata !== want.depth) begin
                        $display("%0t: depth mismatch, expected %0d, actual %0d",
                                 $time, want.depth, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.outcome) begin
                        $display("%0t: outcome mismatch, expected %0d, actual %0d",
                                 $time, want.outcome, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(remap_pixel(pixel_in_t'(s_tdata), bound_width,
                                                      bound_height));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic add_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             depth_t tl, depth_t tr, depth_t bl, depth_t br);
        pixel_in_t p;
        p.map_x = x;
        p.map_y = y;
        p.top_left = tl;
        p.top_right = tr;
        p.bottom_left = bl;
        p.bottom_right = br;
        pending_pixels.push_back(p);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(int size);
        int                   pick;
        int                   ipart;
        logic [FRAC_BITS-1:0] frac;
        pick = $urandom_range(99, 0);
        frac = ($urandom_range(3, 0) == 0) ? '0 : FRAC_BITS'($urandom);
        if (pick < 15) begin
            return COORD_W'($urandom);
        end
        if (pick < 35) begin
            ipart = (size == 0) ? 0 : size - 1 + $urandom_range(1, 0);
        end else begin
            ipart = (size == 0) ? $urandom_range(3, 0) : $urandom_range(size - 1, 0);
        end
        return COORD_W'((ipart << FRAC_BITS) | frac);
    endfunction

    // Most sets sit around a common level so that the consistency test is
    // reached often and lands on both sides of its threshold.
    task automatic add_random_pixels(int n, int w, int h);
        pixel_in_t p;
        int        d[4];
        int        pick;
        int        base;
        int        spread;
        repeat (n) begin
            p.map_x = rand_coord(w);
            p.map_y = rand_coord(h);
            pick = $urandom_range(99, 0);
            base = $urandom_range(65535, 100);
            spread = base / 100;
            foreach (d[i]) begin
                if (pick < 60) begin
                    d[i] = base - spread + $urandom_range(2 * spread, 0);
                    if (d[i] > 65535) d[i] = 65535;
                end else if (pick < 72) begin
                    d[i] = $urandom_range(120, 1);
                end else begin
                    d[i] = $urandom_range(65535, 0);
                end
            end
            if (pick >= 48 && pick < 60) d[$urandom_range(3, 0)] = 0;
            p.top_left = depth_t'(d[0]);
            p.top_right = depth_t'(d[1]);
            p.bottom_left = depth_t'(d[2]);
            p.bottom_right = depth_t'(d[3]);
            pending_pixels.push_back(p);
        end
    endtask

    task automatic set_register(logic [CFG_INDEX_W-1:0] index, logic [SIZE_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_raw_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        set_register(REG_RAW_WIDTH, w);
        set_register(REG_RAW_HEIGHT, h);
        size_settings++;
    endtask

    task automatic drain;
        do @(posedge aclk);
        while (pending_pixels.size() != 0 || s_tvalid || expected_pixels.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic run_pixels(int n, int w, int h, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        add_random_pixels(n, w, h);
        drain();
    endtask

    initial begin
        int w;
        int h;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        add_pixel(0, 0, 1000, 1000, 1000, 1000);
        add_pixel(24'h7FFFFF, 24'h7FFFFF, 65535, 65535, 65535, 65535);
        add_pixel(24'h800000, 0, 5000, 5000, 5000, 5000);
        add_pixel(0, 24'hFFFFFF, 5000, 5000, 5000, 5000);
        add_pixel(639 << FRAC_BITS, 479 << FRAC_BITS, 65535, 65535, 65535, 65535);
        add_pixel((639 << FRAC_BITS) | 1, 0, 2000, 2000, 2000, 2000);
        add_pixel(0, (479 << FRAC_BITS) | 1, 2000, 2000, 2000, 2000);
        add_pixel((638 << FRAC_BITS) | 128, (478 << FRAC_BITS) | 255, 3000, 3010, 2995, 3020);
        add_pixel((10 << FRAC_BITS) | 64, (20 << FRAC_BITS) | 32, 0, 500, 500, 500);
        add_pixel((10 << FRAC_BITS) | 64, (20 << FRAC_BITS) | 32, 500, 0, 500, 500);
        add_pixel((10 << FRAC_BITS) | 64, (20 << FRAC_BITS) | 32, 500, 500, 0, 500);
        add_pixel((10 << FRAC_BITS) | 64, (20 << FRAC_BITS) | 32, 500, 500, 500, 0);
        add_pixel(640 << FRAC_BITS, 0, 0, 0, 0, 0);
        add_pixel(5 << FRAC_BITS, 5 << FRAC_BITS, 0, 1, 65535, 65535);
        add_pixel((1 << FRAC_BITS) | 17, (2 << FRAC_BITS) | 200, 50, 50, 50, 50);
        add_pixel((1 << FRAC_BITS) | 17, (2 << FRAC_BITS) | 200, 99, 99, 99, 99);
        add_pixel((1 << FRAC_BITS) | 17, (2 << FRAC_BITS) | 200, 100, 100, 100, 100);
        add_pixel((3 << FRAC_BITS) | 90, (4 << FRAC_BITS) | 9, 1010, 990, 1000, 1000);
        add_pixel((3 << FRAC_BITS) | 90, (4 << FRAC_BITS) | 9, 1009, 991, 1000, 1000);
        add_pixel((5 << FRAC_BITS) | 255, (7 << FRAC_BITS) | 255, 40000, 40100, 40200, 40300);
        add_pixel((100 << FRAC_BITS) | 128, (200 << FRAC_BITS) | 128, 65535, 65000, 65535,
                  65200);
        add_pixel((5 << FRAC_BITS) | 255, (7 << FRAC_BITS) | 255, 65535, 65535, 65535, 65535);
        add_pixel((6 << FRAC_BITS) | 10, (8 << FRAC_BITS) | 20, 43699, 43699, 43699, 43699);
        add_pixel((6 << FRAC_BITS) | 10, (8 << FRAC_BITS) | 20, 44136, 43699, 43699, 43263);
        drain();

        set_raw_size(15'd32767, 15'd32767);
        run_pixels(150, 32767, 32767, 10, 59);
        set_raw_size(15'd0, 15'd480);
        run_pixels(60, 0, 480, 10, 59);
        set_raw_size(15'd640, 15'd0);
        set_register(REG_SPARE, 15'h7FFF);
        set_register(REG_TOP, 15'd7);
        run_pixels(60, 640, 0, 10, 59);

        set_raw_size(15'd1, 15'd1);
        run_pixels(120, 1, 1, 59, 10);
        set_raw_size(15'd2, 15'd3);
        run_pixels(120, 2, 3, 59, 10);

        w = $urandom_range(32767, 1);
        h = $urandom_range(32767, 1);
        set_raw_size(SIZE_W'(w), SIZE_W'(h));
        run_pixels(150, w, h, 0, 0);
        set_raw_size(15'd320, 15'd240);
        run_pixels(270, 320, 240, 0, 0);

        repeat (2 * LATENCY) @(posedge aclk);
        if (expected_pixels.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_pixels.size());
            mismatches++;
        end
        $display("Checked %0d remapped pixels over %0d raw image sizes, with and without stalls.",
                 pixels_checked, size_settings);
        $display("Outcomes: %0d interpolated, %0d out of bounds, %0d zero neighbor, %0d inconsistent.",
                 outcome_count[OUT_INTERP], outcome_count[OUT_BOUNDS],
                 outcome_count[OUT_ZERO_NBR], outcome_count[OUT_INCONSIST]);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
